// ----- rtl/nearest_palette_color_search_core_assert.svh -----
// Assertion macros shared by the nearest palette color search RTL.
// Include this file inside a module body; it has no other dependencies.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_CORE_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define NPCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define NPCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ----- rtl/npcs_pkg.sv -----
// Package for the nearest palette color search: field widths, operation codes,
// constants and the small arithmetic helper of the distance datapath. No dependencies.
package npcs_pkg;

   localparam int DEFAULT_PALETTE_ENTRIES = 256;
   localparam int COLOR_W = 8;
   localparam int INDEX_W = 8;
   localparam int ACTIVE_W = 9;
   localparam int ENTRY_W = 4 * COLOR_W;
   localparam int SQ_W = 2 * COLOR_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int PROD_W = SUM_W + COLOR_W;
   localparam int ATERM_W = SQ_W + COLOR_W;
   localparam int DIST_W = 27;
   localparam int LEAST_W = 31;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(256);
   localparam logic [COLOR_W-1:0] COLOR_MAX = COLOR_W'(255);
   localparam logic [LEAST_W-1:0] LEAST_INIT = LEAST_W'(1) << 30;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] x,
                                               input logic [COLOR_W-1:0] y);
      logic [COLOR_W-1:0] d;
      d = (x >= y) ? (x - y) : (y - x);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

endpackage

// ----- rtl/npcs_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the palette store; no dependencies.
module npcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/nearest_palette_color_search_core.sv -----
// Top level of the nearest palette color search: palette RAM, scan sequencer,
// distance pipeline and result register. Depends on npcs_pkg, npcs_ram and the assert header.
//
//   Channel  Ports                               Direction  Transfer
//   req      req_valid/req_stall, op, index,rgba  in         valid & !stall
//   rsp      rsp_valid/rsp_stall, best_index      out        valid & !stall
//   csr      csr_wr_en, csr_wr_data               in         wr_en
//
// A write transfer stores its entry in the cycle it is taken and the block is ready again.
// A search reads one palette entry per cycle from the RAM port, then flushes the distance
// pipeline before the result is loaded; with no active entries it skips both steps.
// Reset is synchronous and restores active_entries to 256; the palette is not cleared.
// A waiting result does not block new transfers until the next search needs the register.
module nearest_palette_color_search_core #(
   parameter int PALETTE_ENTRIES = npcs_pkg::DEFAULT_PALETTE_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [npcs_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [npcs_pkg::COLOR_W-1:0]  req_red,
   input  logic [npcs_pkg::COLOR_W-1:0]  req_green,
   input  logic [npcs_pkg::COLOR_W-1:0]  req_blue,
   input  logic [npcs_pkg::COLOR_W-1:0]  req_alpha,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [npcs_pkg::INDEX_W-1:0]  rsp_best_index,
   input  logic                          csr_wr_en,
   input  logic [npcs_pkg::ACTIVE_W-1:0] csr_wr_data
);

   import npcs_pkg::*;

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam int CW = $clog2(PALETTE_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic [ACTIVE_W-1:0] active_ff, active_in;
   logic [CW-1:0] n_ff, n_in, addr_ff, addr_in, n_sat;
   logic v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_best_index_ff, rsp_best_index_in;

   logic [COLOR_W-1:0] q_red_ff, q_green_ff, q_blue_ff, q_alpha_ff;
   logic [AW-1:0] idx0_ff, idx1_ff, idx2_ff;
   logic [SQ_W-1:0] sq_r_ff, sq_g_ff, sq_b_ff, sq_a_ff;
   logic [COLOR_W-1:0] w_ff;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [AW-1:0] best_ff, best_in;
   logic [LEAST_W-1:0] least_ff, least_in;

   logic req_accept, is_search, rsp_load;
   logic ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [SUM_W-1:0] sum3;
   logic [PROD_W-1:0] prod;
   logic [ATERM_W-1:0] aterm;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign is_search = (op_type'(req_op) == OP_SEARCH);
   assign ram_wr_en = req_accept && (op_type'(req_op) == OP_WRITE)
                      && (32'(req_entry_index) < 32'(PALETTE_ENTRIES));
   assign ram_rd_en = (state_ff == ST_SCAN);
   assign ram_rd_addr = addr_ff[AW-1:0];
   assign rsp_load = (state_ff == ST_HOLD) && (!rsp_valid_ff || !rsp_stall);
   assign n_sat = (32'(active_ff) > 32'(PALETTE_ENTRIES)) ? CW'(PALETTE_ENTRIES)
                                                          : CW'(active_ff);

   npcs_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(PALETTE_ENTRIES)
   ) u_palette (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(AW'(req_entry_index)),
      .wr_data({req_red, req_green, req_blue, req_alpha}),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      addr_in = addr_ff;
      active_in = csr_wr_en ? csr_wr_data : active_ff;
      v0_in = ram_rd_en;
      v1_in = v0_ff;
      v2_in = v1_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_search) begin
               n_in = n_sat;
               addr_in = '0;
               state_in = (n_sat == '0) ? ST_HOLD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + CW'(1);
            if (addr_ff == n_ff - CW'(1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!v0_ff && !v1_ff && !v2_ff) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= ACTIVE_RESET;
         n_ff <= '0;
         addr_ff <= '0;
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         n_ff <= n_in;
         addr_ff <= addr_in;
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Distance: weighted color term plus alpha term, alpha term as (x << 8) - x.
   assign sum3 = SUM_W'(sq_r_ff) + SUM_W'(sq_g_ff) + SUM_W'(sq_b_ff);
   assign prod = PROD_W'(sum3) * PROD_W'(w_ff);
   assign aterm = (ATERM_W'(sq_a_ff) << COLOR_W) - ATERM_W'(sq_a_ff);
   assign dist_in = DIST_W'(prod) + DIST_W'(aterm);

   always_comb begin
      best_in = best_ff;
      least_in = least_ff;
      if (req_accept && is_search) begin
         best_in = '0;
         least_in = LEAST_INIT;
      end else if (v2_ff && (LEAST_W'(dist_ff) < least_ff)) begin
         best_in = idx2_ff;
         least_in = LEAST_W'(dist_ff);
      end
      rsp_best_index_in = rsp_load ? INDEX_W'(best_ff) : rsp_best_index_ff;
   end

   always_ff @(posedge clock) begin
      if (req_accept && is_search) begin
         q_red_ff <= req_red;
         q_green_ff <= req_green;
         q_blue_ff <= req_blue;
         q_alpha_ff <= req_alpha;
      end
      idx0_ff <= ram_rd_addr;
      idx1_ff <= idx0_ff;
      idx2_ff <= idx1_ff;
      sq_r_ff <= sq_diff(q_red_ff, ram_rd_data[4*COLOR_W-1:3*COLOR_W]);
      sq_g_ff <= sq_diff(q_green_ff, ram_rd_data[3*COLOR_W-1:2*COLOR_W]);
      sq_b_ff <= sq_diff(q_blue_ff, ram_rd_data[2*COLOR_W-1:COLOR_W]);
      sq_a_ff <= sq_diff(q_alpha_ff, ram_rd_data[COLOR_W-1:0]);
      w_ff <= COLOR_MAX - ram_rd_data[COLOR_W-1:0];
      dist_ff <= dist_in;
      best_ff <= best_in;
      least_ff <= least_in;
      rsp_best_index_ff <= rsp_best_index_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_best_index = rsp_best_index_ff;

`include "nearest_palette_color_search_core_assert.svh"

   `NPCS_ASSERT_NOW(a_pipe_only_busy, clock, reset, v0_ff || v1_ff || v2_ff,
                    state_ff == ST_SCAN || state_ff == ST_FLUSH)
   `NPCS_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == ST_SCAN, addr_ff < n_ff)
   `NPCS_ASSERT_NOW(a_write_when_idle, clock, reset, ram_wr_en, state_ff == ST_IDLE)
   `NPCS_ASSERT_NOW(a_best_in_range, clock, reset, state_ff == ST_HOLD && n_ff != '0,
                    CW'(best_ff) < n_ff)
   `NPCS_ASSERT_NEXT(a_result_loaded, clock, reset, rsp_load,
                     rsp_valid_ff && state_ff == ST_IDLE)

endmodule
